@@ rtl/button_gesture_detector_core_macros.svh @@
// ----------------------------------------------------------------------------
// Button gesture detector assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef BUTTON_GESTURE_DETECTOR_CORE_MACROS_SVH
`define BUTTON_GESTURE_DETECTOR_CORE_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define BGD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define BGD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/bgd_pkg.sv @@
// ----------------------------------------------------------------------------
// Button gesture detector package
// Shared widths, register indexes and state and result types.
// ----------------------------------------------------------------------------
package bgd_pkg;

    localparam int AGE_W       = 16;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

    localparam logic [CFG_INDEX_W-1:0] REG_DOUBLE_CLICK_TICKS = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_TICKS         = CFG_INDEX_W'(1);

    localparam logic [AGE_W-1:0] DOUBLE_CLICK_TICKS_RESET = AGE_W'(300);
    localparam logic [AGE_W-1:0] HOLD_TICKS_RESET         = AGE_W'(1000);

    typedef struct packed {
        logic [AGE_W-1:0] double_click_ticks;
        logic [AGE_W-1:0] hold_ticks;
    } bgd_cfg_t;

    typedef struct packed {
        logic             prev_level;
        logic             click_open;
        logic [AGE_W-1:0] click_age;
        logic             press_open;
        logic [AGE_W-1:0] press_age;
        logic             hold_reported;
    } bgd_state_t;

    typedef struct packed {
        logic changed;
        logic single_click;
        logic double_click;
        logic hold;
        logic is_pressed;
    } bgd_result_t;

    function automatic logic [AGE_W-1:0] sat_inc(input logic [AGE_W-1:0] v);
        return (v == AGE_MAX) ? v : v + AGE_W'(1);
    endfunction

endpackage

@@ rtl/bgd_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// Button gesture detector configuration registers
// Holds the double-click and hold thresholds written over the config port.
// ----------------------------------------------------------------------------
module bgd_cfg_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bgd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bgd_pkg::CFG_DATA_W-1:0]  cfg_data,
    output bgd_pkg::bgd_cfg_t              cfg
);
    import bgd_pkg::*;

    bgd_cfg_t cfg_reg;
    bgd_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_DOUBLE_CLICK_TICKS: cfg_next.double_click_ticks = cfg_data;
                REG_HOLD_TICKS:         cfg_next.hold_ticks         = cfg_data;
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.double_click_ticks <= DOUBLE_CLICK_TICKS_RESET;
            cfg_reg.hold_ticks         <= HOLD_TICKS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ rtl/bgd_step.sv @@
// ----------------------------------------------------------------------------
// Button gesture detector step logic
// Computes the next gesture state and the pulses for one level sample.
// ----------------------------------------------------------------------------
module bgd_step
(
    input  logic                level,
    input  bgd_pkg::bgd_cfg_t   cfg,
    input  bgd_pkg::bgd_state_t state,
    output bgd_pkg::bgd_state_t state_next,
    output bgd_pkg::bgd_result_t result
);
    import bgd_pkg::*;

    logic             changed;
    logic             single_click;
    logic             double_click;
    logic             hold;
    logic [AGE_W-1:0] click_age_inc;

    always_comb
    begin
        state_next    = state;
        changed       = level != state.prev_level;
        single_click  = 1'b0;
        double_click  = 1'b0;
        hold          = 1'b0;
        click_age_inc = sat_inc(state.click_age);

        // The open window ages first and may expire.
        if (state.click_open)
        begin
            state_next.click_age = click_age_inc;
            if (click_age_inc > cfg.double_click_ticks)
            begin
                state_next.click_open = 1'b0;
                single_click          = 1'b1;
            end
        end
        if (state.press_open)
        begin
            state_next.press_age = sat_inc(state.press_age);
        end

        if (!level)
        begin
            if (changed)
            begin
                if (state_next.click_open)
                begin
                    double_click          = 1'b1;
                    state_next.click_open = 1'b0;
                end
                else
                begin
                    state_next.click_open = 1'b1;
                    state_next.click_age  = '0;
                end
                state_next.press_open = 1'b1;
                state_next.press_age  = '0;
            end
        end
        else
        begin
            state_next.press_open = 1'b0;
        end

        // A long press reports once and cancels the pending click.
        if (state_next.press_open && (state_next.press_age > cfg.hold_ticks))
        begin
            hold                     = !state.hold_reported;
            state_next.hold_reported = 1'b1;
            state_next.click_open    = 1'b0;
        end
        else
        begin
            state_next.hold_reported = 1'b0;
        end

        state_next.prev_level = level;

        result.changed      = changed;
        result.single_click = single_click;
        result.double_click = double_click;
        result.hold         = hold;
        result.is_pressed   = !level;
    end

endmodule

@@ rtl/button_gesture_detector_core.sv @@
// ----------------------------------------------------------------------------
// Button gesture detector core
// Turns one sampled button level per word into change, click, double-click
// and hold pulses plus the current pressed level.
//
// The input channel takes one level word per cycle while input ready is high (0 pressed, 1 released).
// Each input word yields exactly one output word on the output channel.
// A word is held in an input register, runs through the gesture logic and
// lands in the result register, from which it is presented. Throughput is
// one word per cycle while the receiver does not stall, set by the single
// registered pass through the gesture update.
// When the receiver stalls, the result register holds its word and the input
// register fills; input ready drops only once both are occupied.
// The configuration channel is always ready: index 0 writes the double-click
// limit and index 1 the hold limit, both in ticks; other indexes are ignored.
// Write it only while no word is in flight.
// Reset restores the limits to 300 and 1000 ticks, marks the button released,
// closes any click window or press, and empties both registers.
// ----------------------------------------------------------------------------
module button_gesture_detector_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            level,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            changed,
    output logic                            single_click,
    output logic                            double_click,
    output logic                            hold,
    output logic                            is_pressed,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bgd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bgd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bgd_pkg::*;

    bgd_cfg_t    cfg;
    bgd_state_t  state_reg;
    bgd_state_t  state_next;
    bgd_result_t step_result;
    bgd_result_t result_reg;

    logic in_valid_reg;
    logic level_reg;
    logic out_valid_reg;
    logic result_load;

    bgd_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bgd_step u_step
    (
        .level      (level_reg),
        .cfg        (cfg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (step_result)
    );

    assign result_load = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready    = !in_valid_reg || result_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg            <= 1'b0;
            out_valid_reg           <= 1'b0;
            state_reg.prev_level    <= 1'b1;
            state_reg.click_open    <= 1'b0;
            state_reg.click_age     <= '0;
            state_reg.press_open    <= 1'b0;
            state_reg.press_age     <= '0;
            state_reg.hold_reported <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (result_load)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            level_reg <= level;
        end
        if (result_load)
        begin
            result_reg <= step_result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign changed      = result_reg.changed;
    assign single_click = result_reg.single_click;
    assign double_click = result_reg.double_click;
    assign hold         = result_reg.hold;
    assign is_pressed   = result_reg.is_pressed;

endmodule

@@ rtl/bgd_checker.sv @@
// ----------------------------------------------------------------------------
// Button gesture detector checker
// Port-level properties of the gesture pulses and the output channel.
// ----------------------------------------------------------------------------
`include "button_gesture_detector_core_macros.svh"

module bgd_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            level,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic                            changed,
    input logic                            single_click,
    input logic                            double_click,
    input logic                            hold,
    input logic                            is_pressed,
    input logic                            cfg_valid,
    input logic                            cfg_ready,
    input logic [bgd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input logic [bgd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    logic unused_ok;

    assign unused_ok = &{in_valid, in_ready, level, cfg_valid, cfg_ready, cfg_index, cfg_data};

    // A stalled result word stays presented.
    `BGD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result word dropped while stalled")

    // An expiring window opens the next press as a new window, never a double.
    `BGD_ASSERT_SAME(a_click_excl, out_valid, !(single_click && double_click), "single and double click together")

    // A double click comes only with a fresh press.
    `BGD_ASSERT_SAME(a_double_edge, out_valid && double_click, changed && is_pressed, "double click without a press edge")

    // A hold needs a press that has lasted past its first tick.
    `BGD_ASSERT_SAME(a_hold_press, out_valid && hold, is_pressed && !changed, "hold without a lasting press")

endmodule

bind button_gesture_detector_core bgd_checker u_bgd_checker (.*);

@@ verif/button_gesture_detector_checker.sv @@
// ----------------------------------------------------------------------------
// Button gesture detector checker
// Follows the level, result and register channels of the detector. It keeps
// its own copy of the gesture state and the two limits, predicts one result
// word for every accepted level word, and compares each accepted result word
// field by field against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module button_gesture_detector_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic                            level,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic                            changed,
    input  logic                            single_click,
    input  logic                            double_click,
    input  logic                            hold,
    input  logic                            is_pressed,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [bgd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bgd_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              mismatches,
    output int                              backlog,
    output int                              singles_seen,
    output int                              doubles_seen,
    output int                              holds_seen
);
    import bgd_pkg::*;

    bgd_cfg_t    limits;
    bgd_state_t  btn;
    bgd_result_t gestures_due[$];

    function automatic bgd_result_t advance_gesture(input logic lvl);
        bgd_result_t r;
        r            = '0;
        r.changed    = (lvl != btn.prev_level);
        r.is_pressed = (lvl == 1'b0);
        if (btn.click_open)
        begin
            if (btn.click_age != AGE_MAX)
                btn.click_age = btn.click_age + 1'b1;
            if (btn.click_age > limits.double_click_ticks)
            begin
                btn.click_open = 1'b0;
                r.single_click = 1'b1;
            end
        end
        if (btn.press_open && btn.press_age != AGE_MAX)
            btn.press_age = btn.press_age + 1'b1;
        if (lvl == 1'b0)
        begin
            if (r.changed)
            begin
                if (btn.click_open)
                begin
                    r.double_click = 1'b1;
                    btn.click_open = 1'b0;
                end
                else
                begin
                    btn.click_open = 1'b1;
                    btn.click_age  = '0;
                end
                btn.press_open = 1'b1;
                btn.press_age  = '0;
            end
        end
        else
            btn.press_open = 1'b0;
        if (btn.press_open && btn.press_age > limits.hold_ticks)
        begin
            r.hold            = !btn.hold_reported;
            btn.hold_reported = 1'b1;
            btn.click_open    = 1'b0;
        end
        else
            btn.hold_reported = 1'b0;
        btn.prev_level = lvl;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        bgd_result_t want;
        bgd_result_t got;
        if (!rst_n)
        begin
            limits.double_click_ticks = DOUBLE_CLICK_TICKS_RESET;
            limits.hold_ticks         = HOLD_TICKS_RESET;
            btn                       = '0;
            btn.prev_level            = 1'b1;
            gestures_due.delete();
            mismatches   = 0;
            backlog      = 0;
            singles_seen = 0;
            doubles_seen = 0;
            holds_seen   = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_DOUBLE_CLICK_TICKS: limits.double_click_ticks = cfg_data;
                    REG_HOLD_TICKS:         limits.hold_ticks         = cfg_data;
                    default:                ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                got.changed      = changed;
                got.single_click = single_click;
                got.double_click = double_click;
                got.hold         = hold;
                got.is_pressed   = is_pressed;
                singles_seen += int'(single_click === 1'b1);
                doubles_seen += int'(double_click === 1'b1);
                holds_seen   += int'(hold === 1'b1);
                if (gestures_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("At %0t: result word %b arrived with none expected",
                                 $realtime, got);
                end
                else
                begin
                    want = gestures_due.pop_front();
                    if (got.changed !== want.changed ||
                        got.single_click !== want.single_click ||
                        got.double_click !== want.double_click ||
                        got.hold !== want.hold ||
                        got.is_pressed !== want.is_pressed)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"At %0t: changed/single/double/hold/pressed ",
                                      "expected %b got %b"}, $realtime, want, got);
                    end
                end
            end
            if (in_valid && in_ready)
                gestures_due.push_back(advance_gesture(level));
            backlog = gestures_due.size();
        end
    end

endmodule

@@ verif/tb_button_gesture_detector_core.sv @@
// ----------------------------------------------------------------------------
// Button gesture detector testbench
// Drives level words into the detector under several idle and stall mixes
// and several limit settings, including zero and full-scale limits. A
// checker beside the block predicts and compares every result word; this
// module makes the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_button_gesture_detector_core;
    import bgd_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = '1;
    localparam int HOLDOFF_CYCLES  = 40;
    localparam int WORDS_PER_PHASE = 90;
    localparam int LONG_RUN        = 20;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    logic                   level     = 1'b1;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic                   changed;
    logic                   single_click;
    logic                   double_click;
    logic                   hold;
    logic                   is_pressed;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int mismatches;
    int backlog;
    int singles_seen;
    int doubles_seen;
    int holds_seen;

    int send_idle_pct = 0;
    int rx_stall_pct  = 0;
    int holdoff_req   = 0;
    int holdoff_seen  = 0;
    int holdoff_left  = 0;
    int words_sent    = 0;
    int cfg_writes    = 0;
    int dct_lim       = 300;
    int hold_lim      = 1000;

    int dct_plan[8]  = '{3, 1, 8, 0, 12, 5, 2, 20};
    int hold_plan[8] = '{6, 1, 20, 5, 3, 40, 2, 10};
    int idle_plan[4] = '{0, 71, 0, 15};
    int stall_plan[4] = '{0, 0, 71, 15};

    button_gesture_detector_core uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .level        (level),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .changed      (changed),
        .single_click (single_click),
        .double_click (double_click),
        .hold         (hold),
        .is_pressed   (is_pressed),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    button_gesture_detector_checker gesture_checker
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .level        (level),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .changed      (changed),
        .single_click (single_click),
        .double_click (double_click),
        .hold         (hold),
        .is_pressed   (is_pressed),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .backlog      (backlog),
        .singles_seen (singles_seen),
        .doubles_seen (doubles_seen),
        .holds_seen   (holds_seen)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        if (holdoff_left > 0)
        begin
            out_ready    = 1'b0;
            holdoff_left = holdoff_left - 1;
        end
        else if (holdoff_req != holdoff_seen)
        begin
            holdoff_seen = holdoff_req;
            holdoff_left = HOLDOFF_CYCLES;
            out_ready    = 1'b0;
        end
        else
            out_ready = ($urandom_range(99) >= rx_stall_pct);
    end

    task automatic send_word(input logic lvl);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        level    = lvl;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        words_sent++;
    endtask

    task automatic send_run(input logic lvl, input int count);
        for (int i = 0; i < count; i++)
            send_word(lvl);
    endtask

    task automatic wait_idle();
        in_valid = 1'b0;
        while (backlog != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
        cfg_writes++;
    endtask

    task automatic set_limits(input int dct, input int hld);
        wait_idle();
        write_reg(REG_DOUBLE_CLICK_TICKS, CFG_DATA_W'(dct));
        write_reg(REG_HOLD_TICKS, CFG_DATA_W'(hld));
        dct_lim  = dct;
        hold_lim = hld;
    endtask

    task automatic run_gestures(input int count);
        int target;
        int press_max;
        int release_max;
        target      = words_sent + count;
        press_max   = (hold_lim > 40) ? 43 : hold_lim + 3;
        release_max = (dct_lim > 40) ? 43 : dct_lim + 3;
        while (words_sent < target)
        begin
            if ($urandom_range(99) < 15)
                send_word(1'($urandom_range(1)));
            else
            begin
                send_run(1'b0, $urandom_range(press_max, 1));
                send_run(1'b1, $urandom_range(release_max, 1));
            end
        end
    endtask

    initial
    begin
        int guard;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_word(1'b1);
        send_word(1'b0);
        send_word(1'b1);
        send_word(1'b0);
        send_word(1'b1);
        wait_idle();
        write_reg(REG_UNMAPPED, '0);

        set_limits(0, 0);
        send_run(1'b0, 3);
        send_word(1'b1);

        set_limits(1, 3);
        send_word(1'b0);
        send_word(1'b1);
        send_word(1'b0);
        send_run(1'b1, 3);

        set_limits(5, 2);
        send_run(1'b0, 4);
        send_run(1'b1, 3);

        // Full-scale limits: no window expires and no hold fires.
        set_limits(32'hFFFF, 32'hFFFF);
        send_word(1'b0);
        send_run(1'b1, LONG_RUN);
        send_word(1'b0);
        send_run(1'b0, LONG_RUN);
        send_word(1'b1);

        // One below full scale: long presses stay quiet as well.
        set_limits(32'hFFFE, 32'hFFFE);
        send_run(1'b0, LONG_RUN);
        send_word(1'b1);

        for (int p = 0; p < 8; p++)
        begin
            set_limits(dct_plan[p], hold_plan[p]);
            send_idle_pct = idle_plan[p % 4];
            rx_stall_pct  = stall_plan[p % 4];
            if (p % 4 == 0)
                holdoff_req++;
            run_gestures(WORDS_PER_PHASE);
        end

        in_valid     = 1'b0;
        rx_stall_pct = 0;
        guard        = 0;
        while (backlog != 0 && guard < 5000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (8) @(negedge clk);

        if (backlog != 0)
            $display("%0d result words never arrived", backlog);
        $display("Sent %0d level words under %0d register writes and four handshake mixes.",
                 words_sent, cfg_writes);
        $display("Observed %0d single clicks, %0d double clicks and %0d holds.",
                 singles_seen, doubles_seen, holds_seen);
        if (mismatches == 0 && backlog == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("Run did not finish in the allotted time.");
        $display("simulation failed");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/bgd_pkg.sv
rtl/bgd_cfg_regs.sv
rtl/bgd_step.sv
rtl/button_gesture_detector_core.sv
rtl/bgd_checker.sv
verif/button_gesture_detector_checker.sv
verif/tb_button_gesture_detector_core.sv
